// File: hdl/gphc_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the go-to-point
// heading controller. No dependencies.
package gphc_pkg;

  // Defaults for the top-level parameters
  localparam int POS_BITS_DEF        = 20;
  localparam int ANGLE_FRAC_BITS_DEF = 13;
  localparam int CORDIC_STEPS_DEF    = 16;

  // Fixed field widths
  localparam int HEAD_W     = 16;
  localparam int TOL_W      = 15;
  localparam int ARR_W      = 20;
  localparam int SPD_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int OUT_DW     = ((SPD_W + HEAD_W + 7) / 8) * 8;

  // CORDIC geometry: vectors are prescaled to 40 bits of magnitude
  localparam int XW     = 44;
  localparam int ZC_W   = 34;
  localparam int STEP_W = 5;
  localparam int PRE_TOP = 40;

  localparam logic signed [63:0] PI_Q30      = 64'sd3373259426;
  localparam logic signed [63:0] HALF_PI_Q30 = 64'sd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOL = 2'd0,
    CFG_ARR = 2'd1,
    CFG_SPD = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    CMD_SET_GOAL = 1'b0,
    CMD_POSE     = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    DP_NOP, DP_LOAD_GOAL, DP_START, DP_ITER, DP_RBASE, DP_WRAP,
    DP_ROUND, DP_SQ_X, DP_SQ_Z, DP_SQ_A, DP_EMIT
  } dp_op_e;

  typedef enum logic [3:0] {
    S_IDLE, S_ITER, S_RBASE, S_WRAP, S_ROUND, S_SQX, S_SQZ, S_SQA, S_EMIT
  } state_e;

  typedef struct packed {
    dp_op_e              op;
    logic [STEP_W-1:0]   step;
  } dp_cmd_t;

  typedef struct packed {
    logic zero_d;
    logic r_neg;
    logic r_hi;
    logic turn;
    logic far;
  } dp_stat_t;

  // atan(2^-i) in Q30
  function automatic logic signed [ZC_W-1:0] atan_q30(input logic [STEP_W-1:0] i);
    logic signed [ZC_W-1:0] v;
    case (i)
      5'd0:  v = 34'sd843314857;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043837;
      5'd3:  v = 34'sd133525159;
      5'd4:  v = 34'sd67021687;
      5'd5:  v = 34'sd33543516;
      5'd6:  v = 34'sd16775851;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194283;
      5'd9:  v = 34'sd2097149;
      5'd10: v = 34'sd1048576;
      5'd11: v = 34'sd524288;
      5'd12: v = 34'sd262144;
      5'd13: v = 34'sd131072;
      5'd14: v = 34'sd65536;
      5'd15: v = 34'sd32768;
      5'd16: v = 34'sd16384;
      5'd17: v = 34'sd8192;
      5'd18: v = 34'sd4096;
      5'd19: v = 34'sd2048;
      5'd20: v = 34'sd1024;
      5'd21: v = 34'sd512;
      5'd22: v = 34'sd256;
      5'd23: v = 34'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: hdl/gphc_ctrl.sv
// Sequencer for the heading controller: steps the datapath through CORDIC,
// angle wrap, rounding and the distance test. Depends on gphc_pkg.
module gphc_ctrl import gphc_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_valid_i,
  input  cmd_e     s_cmd_i,
  output logic     s_ready_o,
  output logic     m_valid_o,
  input  logic     m_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     active_o
);

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              active_q, active_d;
  logic              mvalid_q, mvalid_d;

  // State and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      step_q   <= '0;
      active_q <= 1'b0;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      active_q <= active_d;
      mvalid_q <= mvalid_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    active_d   = active_q;
    mvalid_d   = mvalid_q & ~m_ready_i;
    cmd_o.op   = DP_NOP;
    cmd_o.step = step_q;
    s_ready_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          if (s_cmd_i == CMD_SET_GOAL) begin
            cmd_o.op = DP_LOAD_GOAL;
            active_d = 1'b1;
          end else if (active_q) begin
            cmd_o.op = DP_START;
            step_d   = '0;
            state_d  = S_ITER;
          end
        end
      end
      S_ITER: begin
        cmd_o.op = DP_ITER;
        step_d   = step_q + 1'b1;
        if (step_q == STEP_W'(CORDIC_STEPS - 1)) state_d = S_RBASE;
      end
      S_RBASE: begin
        cmd_o.op = DP_RBASE;
        state_d  = S_WRAP;
      end
      S_WRAP: begin
        if (stat_i.r_neg || stat_i.r_hi) cmd_o.op = DP_WRAP;
        else state_d = S_ROUND;
      end
      S_ROUND: begin
        cmd_o.op = DP_ROUND;
        state_d  = S_SQX;
      end
      S_SQX: begin
        cmd_o.op = DP_SQ_X;
        state_d  = S_SQZ;
      end
      S_SQZ: begin
        cmd_o.op = DP_SQ_Z;
        state_d  = S_SQA;
      end
      S_SQA: begin
        cmd_o.op = DP_SQ_A;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        // wait for the output register to be free
        if (!mvalid_q || m_ready_i) begin
          cmd_o.op = DP_EMIT;
          mvalid_d = 1'b1;
          if (!stat_i.turn && !stat_i.far) active_d = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign m_valid_o = mvalid_q;
  assign active_o  = active_q;

endmodule

// File: hdl/gphc_dp.sv
// Datapath of the heading controller: goal store, vectoring CORDIC, angle wrap
// and rounding, distance-squared test and result register. Depends on gphc_pkg.
module gphc_dp import gphc_pkg::*; #(
  parameter int POS_BITS        = POS_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  dp_cmd_t                    cmd_i,
  input  logic signed [POS_BITS-1:0] goal_x_i,
  input  logic signed [POS_BITS-1:0] goal_z_i,
  input  logic signed [POS_BITS-1:0] pose_x_i,
  input  logic signed [POS_BITS-1:0] pose_z_i,
  input  logic signed [HEAD_W-1:0]   heading_i,
  input  logic [TOL_W-1:0]           tol_i,
  input  logic [ARR_W-1:0]           arr_i,
  input  logic [SPD_W-1:0]           spd_i,
  output dp_stat_t                   stat_o,
  output logic [SPD_W-1:0]           speed_o,
  output logic signed [HEAD_W-1:0]   turn_o,
  output logic                       arrived_o
);

  localparam int DW  = POS_BITS + 1;
  localparam int PRE = PRE_TOP - POS_BITS;
  localparam int ASH = 30 - ANGLE_FRAC_BITS;
  localparam int AW  = HEAD_W + ASH;
  localparam int ZW  = ((AW > ZC_W) ? AW : ZC_W) + 3;
  localparam int BW  = ANGLE_FRAC_BITS + 3;
  localparam int MW  = (DW > ARR_W + 1) ? DW : ARR_W + 1;
  localparam int PW  = 2 * ARR_W;

  localparam logic signed [ZW-1:0]   PI_W   = ZW'(PI_Q30);
  localparam logic signed [ZW-1:0]   TWO_PI = ZW'(2 * PI_Q30);
  localparam logic signed [ZW-1:0]   HALF_W = ZW'(HALF_PI_Q30);
  localparam logic signed [ZW-1:0]   RND    = ZW'(64'sd1 <<< (ASH - 1));
  localparam logic signed [ZC_W-1:0] HALF_Z = ZC_W'(HALF_PI_Q30);

  logic signed [POS_BITS-1:0] gx_q, gz_q;
  logic signed [DW-1:0]       dx_q, dz_q, dx_n, dz_n;
  logic signed [HEAD_W-1:0]   alpha_q;
  logic signed [XW-1:0]       x_q, y_q, x0, y0, xs, ys;
  logic signed [ZC_W-1:0]     z_q;
  logic signed [ZW-1:0]       r_q, bfull, brnd;
  logic signed [BW-1:0]       beta_q;
  logic [BW-1:0]              mag;
  logic [DW-1:0]              adx, adz;
  logic [ARR_W-1:0]           mul_a;
  logic [PW-1:0]              mul_w, prod_q;
  logic [PW:0]                acc_q;
  logic                       coarse;
  logic [SPD_W-1:0]           spd_q;
  logic signed [HEAD_W-1:0]   turn_q;
  logic                       arr_q;

  // Difference to the target and its prescaled form
  assign dx_n = DW'(gx_q) - DW'(pose_x_i);
  assign dz_n = DW'(gz_q) - DW'(pose_z_i);
  assign x0   = XW'(dx_n) <<< PRE;
  assign y0   = XW'(dz_n) <<< PRE;
  assign xs   = x_q >>> cmd_i.step;
  assign ys   = y_q >>> cmd_i.step;

  // Rounding of the wrapped angle to the output scale
  assign bfull = (r_q == '0) ? PI_W : (r_q - PI_W);
  assign brnd  = (bfull + RND) >>> ASH;

  // Magnitudes for the turn and distance tests
  assign mag    = (beta_q < 0) ? -beta_q : beta_q;
  assign adx    = (dx_q < 0) ? -dx_q : dx_q;
  assign adz    = (dz_q < 0) ? -dz_q : dz_q;
  assign coarse = (MW'(adx) > MW'(arr_i)) || (MW'(adz) > MW'(arr_i));

  // One shared squarer
  always_comb begin
    case (cmd_i.op)
      DP_SQ_X: mul_a = ARR_W'(adx);
      DP_SQ_Z: mul_a = ARR_W'(adz);
      default: mul_a = arr_i;
    endcase
  end
  assign mul_w = PW'(mul_a) * PW'(mul_a);

  assign stat_o.zero_d = (dx_q == '0) && (dz_q == '0);
  assign stat_o.r_neg  = (r_q < 0);
  assign stat_o.r_hi   = (r_q >= TWO_PI);
  assign stat_o.turn   = 32'(mag) > 32'(tol_i);
  assign stat_o.far    = coarse || (acc_q > (PW + 1)'(prod_q));

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LOAD_GOAL: begin
        gx_q <= goal_x_i;
        gz_q <= goal_z_i;
      end
      DP_START: begin
        dx_q    <= dx_n;
        dz_q    <= dz_n;
        alpha_q <= heading_i;
        // quadrant pre-rotation for the left half plane
        if (x0 < 0) begin
          if (y0 >= 0) begin
            x_q <= y0;
            y_q <= -x0;
            z_q <= HALF_Z;
          end else begin
            x_q <= -y0;
            y_q <= x0;
            z_q <= -HALF_Z;
          end
        end else begin
          x_q <= x0;
          y_q <= y0;
          z_q <= '0;
        end
      end
      DP_ITER: begin
        if (y_q > 0) begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + atan_q30(cmd_i.step);
        end else begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - atan_q30(cmd_i.step);
        end
      end
      DP_RBASE: r_q <= HALF_W - (ZW'(alpha_q) <<< ASH) - ZW'(z_q) + PI_W;
      DP_WRAP: begin
        if (r_q < 0) r_q <= r_q + TWO_PI;
        else         r_q <= r_q - TWO_PI;
      end
      DP_ROUND: beta_q <= stat_o.zero_d ? '0 : BW'(brnd);
      DP_SQ_X:  prod_q <= mul_w;
      DP_SQ_Z: begin
        acc_q  <= (PW + 1)'(prod_q);
        prod_q <= mul_w;
      end
      DP_SQ_A: begin
        acc_q  <= acc_q + (PW + 1)'(prod_q);
        prod_q <= mul_w;
      end
      DP_EMIT: begin
        if (stat_o.turn) begin
          spd_q  <= '0;
          turn_q <= HEAD_W'(beta_q);
          arr_q  <= 1'b0;
        end else if (stat_o.far) begin
          spd_q  <= spd_i;
          turn_q <= '0;
          arr_q  <= 1'b0;
        end else begin
          spd_q  <= '0;
          turn_q <= '0;
          arr_q  <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign speed_o   = spd_q;
  assign turn_o    = turn_q;
  assign arrived_o = arr_q;

endmodule

// File: hdl/goto_point_heading_controller_unit.sv
// Top level of the go-to-point heading controller: stream ports, configuration
// registers, sequencer and datapath. Depends on gphc_pkg, gphc_ctrl, gphc_dp.
//
//  channel   | direction | transfers
//  s_axis    | in        | set-target or pose tick (tuser = command)
//  m_axis    | out       | speed / turn command, tuser = arrived
//  cfg       | in        | register write, index 0..2
//
// A pose tick with a target held runs CORDIC_STEPS iterations, the base angle,
// any 2*pi wrap steps (usually none or one), rounding, three squaring steps and
// the emit. A set-target item or a tick without target gives no result.
// Reset clears the target and loads the register defaults.
// The output register holds a result while m_axis_tready is low; new input is
// accepted meanwhile, and the next result waits only for that register.
module goto_point_heading_controller_unit import gphc_pkg::*; #(
  parameter int POS_BITS        = POS_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
  parameter int IN_DW           = ((4 * POS_BITS + HEAD_W + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // goal_x, goal_z, pose_x, pose_z, pose_heading
  input  logic [IN_DW-1:0]      s_axis_tdata,
  // command
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // advance_speed, turn_rate
  output logic [OUT_DW-1:0]     m_axis_tdata,
  // arrived
  output logic                  m_axis_tuser,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [TOL_W-1:0]           tol_q;
  logic [ARR_W-1:0]           arr_q;
  logic [SPD_W-1:0]           spd_q;
  logic signed [POS_BITS-1:0] goal_x, goal_z, pose_x, pose_z;
  logic signed [HEAD_W-1:0]   heading;
  dp_cmd_t                    dp_cmd;
  dp_stat_t                   dp_stat;
  logic [SPD_W-1:0]           speed;
  logic signed [HEAD_W-1:0]   turn;
  logic                       arrived;
  logic                       goal_active;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_W'(8);
      arr_q <= ARR_W'(150);
      spd_q <= SPD_W'(1000);
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TOL: tol_q <= cfg_data_i[TOL_W-1:0];
        CFG_ARR: arr_q <= cfg_data_i[ARR_W-1:0];
        CFG_SPD: spd_q <= cfg_data_i[SPD_W-1:0];
        default: ;
      endcase
    end
  end

  // Input field unpacking
  assign goal_x  = s_axis_tdata[POS_BITS-1:0];
  assign goal_z  = s_axis_tdata[2*POS_BITS-1:POS_BITS];
  assign pose_x  = s_axis_tdata[3*POS_BITS-1:2*POS_BITS];
  assign pose_z  = s_axis_tdata[4*POS_BITS-1:3*POS_BITS];
  assign heading = s_axis_tdata[4*POS_BITS+HEAD_W-1:4*POS_BITS];

  gphc_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid),
    .s_cmd_i  (cmd_e'(s_axis_tuser)),
    .s_ready_o(s_axis_tready),
    .m_valid_o(m_axis_tvalid),
    .m_ready_i(m_axis_tready),
    .stat_i   (dp_stat),
    .cmd_o    (dp_cmd),
    .active_o (goal_active)
  );

  gphc_dp #(
    .POS_BITS       (POS_BITS),
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .cmd_i    (dp_cmd),
    .goal_x_i (goal_x),
    .goal_z_i (goal_z),
    .pose_x_i (pose_x),
    .pose_z_i (pose_z),
    .heading_i(heading),
    .tol_i    (tol_q),
    .arr_i    (arr_q),
    .spd_i    (spd_q),
    .stat_o   (dp_stat),
    .speed_o  (speed),
    .turn_o   (turn),
    .arrived_o(arrived)
  );

  // Output packing
  assign m_axis_tdata = OUT_DW'({turn, speed});
  assign m_axis_tuser = arrived;

  // Arrival is a full stop
  a_arrive_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> speed == '0 && turn == '0)
    else $error("arrival with non-zero command");

  // Driving and turning are exclusive
  a_drive_no_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && speed != '0 |-> turn == '0)
    else $error("speed and turn both set");

  // A set-target transaction leaves a target held
  a_goal_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_SET_GOAL |=> goal_active)
    else $error("target not held after set");

endmodule
